// ===== hw/rtl/min_priority_queue_defines.svh =====
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mpq_pkg.sv =====
`timescale 1ns / 1ps

package mpq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int QCOUNT_W = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam logic signed [VAL_W-1:0] VALUE_NONE = -32'sd1;

	typedef struct packed {
		op_t                      operation;
		logic signed [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  removed_value;
		status_t                  status;
		logic [QCOUNT_W-1:0]      queue_count;
	} rsp_t;

endpackage

// ===== hw/rtl/mpq_ram.sv =====
`timescale 1ns / 1ps

module mpq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/min_priority_queue.sv =====
`timescale 1ns / 1ps
// Ascending priority queue of signed 32-bit values, up to CAPACITY entries.
// req channel (valid/ready): operation OP_INSERT appends value, OP_REMOVE
// takes out the smallest stored value. rsp channel (valid/ready): one
// result per request with removed_value, status and queue_count.
// Values sit unsorted in a single-port-write, registered-read RAM. An
// insert writes one entry; a remove reads the stored entries one per cycle
// to find the minimum, then moves the last entry into the freed slot.
// An insert, a refused insert or a remove on an empty queue goes from
// S_IDLE straight to S_DONE; a remove with entries stored passes S_SCAN,
// S_PUT, then S_DONE, which raises rsp_valid once the rsp register frees.
// One request is worked on at a time; req_ready is high only while the
// block is idle, so a new request is taken only after the last result has
// left S_DONE, and the RAM scan of a remove sets the sustained rate.
// A finished result waits in the rsp register while the next request is
// taken; a stalled receiver holds rsp and the block waits with its next
// result until the register frees up.
// Reset empties the queue at once (count cleared; the RAM is not swept)
// and drops any pending result.
module min_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mpq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mpq_pkg::rsp_t rsp
);
	import mpq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PUT,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        rd_addr_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic signed [VAL_W-1:0] last_val_q;
	rsp_t                    res_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic [IDX_W-1:0]        ram_raddr;
	logic [VAL_W-1:0]        ram_rdata;
	logic signed [VAL_W-1:0] rd_val;

	logic                    req_xfer;
	logic                    full;
	logic                    scan_last;
	logic                    take_new;
	logic                    rsp_free;

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign rd_val    = $signed(ram_rdata);
	assign scan_last = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q);
	assign take_new  = (rd_addr_q == '0) || (rd_val < best_val_q);
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// drive RAM: insert writes at the tail, put moves the last entry down
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = req.value;
		if (state_q == S_PUT) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = last_val_q;
		end else if (req_xfer && req.operation == OP_INSERT && !full) begin
			ram_we = 1'b1;
		end
	end

	// read entry 0 on a remove transfer, then step through the entries
	assign ram_raddr = (state_q == S_SCAN) ? rd_addr_q + IDX_W'(1) : '0;

	mpq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VAL_W),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequence one request: accept, scan, put back, hand off result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						if (req.operation == OP_INSERT) begin
							res_q.removed_value <= '0;
							state_q             <= S_DONE;
							if (!full) begin
								count_q           <= count_q + CNT_W'(1);
								res_q.status      <= ST_INSERTED;
								res_q.queue_count <= QCOUNT_W'(count_q + CNT_W'(1));
							end else begin
								res_q.status      <= ST_FULL;
								res_q.queue_count <= QCOUNT_W'(count_q);
							end
						end else if (count_q == '0) begin
							res_q.removed_value <= VALUE_NONE;
							res_q.status        <= ST_EMPTY;
							res_q.queue_count   <= '0;
							state_q             <= S_DONE;
						end else begin
							rd_addr_q <= '0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// keep the earliest smallest value
					if (take_new) begin
						best_val_q <= rd_val;
						best_idx_q <= rd_addr_q;
					end
					if (scan_last) begin
						last_val_q <= rd_val;
						state_q    <= S_PUT;
					end else begin
						rd_addr_q <= rd_addr_q + IDX_W'(1);
					end
				end
				S_PUT: begin
					count_q             <= count_q - CNT_W'(1);
					res_q.removed_value <= best_val_q;
					res_q.status        <= ST_REMOVED;
					res_q.queue_count   <= QCOUNT_W'(count_q - CNT_W'(1));
					state_q             <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/mpq_checker.sv =====
`timescale 1ns / 1ps
`include "min_priority_queue_defines.svh"

module mpq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input mpq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input mpq_pkg::rsp_t rsp
);
	import mpq_pkg::*;

	// stalled result holds
	`MPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// empty remove reports the marker value and an empty count
	`MPQ_ASSERT_NOW(a_empty, rsp_valid && rsp.status == ST_EMPTY, rsp.removed_value == VALUE_NONE && rsp.queue_count == '0, "bad empty result")

	// inserts, taken or refused, report zero
	`MPQ_ASSERT_NOW(a_insert_zero, rsp_valid && (rsp.status == ST_INSERTED || rsp.status == ST_FULL), rsp.removed_value == '0, "insert result not zero")

	// no result shows up right after a transfer into an idle output
	`MPQ_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid, "result too early")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import mpq_pkg::*;

	localparam int RANDOM_ITEMS   = 1400;
	localparam int IDLE_LIMIT     = 3000;
	localparam int DRAIN_CYCLES   = 25;
	localparam int MAX_MSG_LINES  = 40;

	// receiver stall styles
	localparam int READY_FREE     = 0;
	localparam int READY_CHOPPY   = 1;
	localparam int READY_BURSTY   = 2;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req     = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// typed expectation riding along with the request currently offered
	bit   tag_typed = 1'b0;
	rsp_t tag_want  = '0;

	// shadow copy of the queue contents, insertion order
	logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
	int shadow_count = 0;

	rsp_t pending_results[$];
	dir_row_t dir_rows[$];
	int err_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	int rdy_mode = READY_FREE;
	int rdy_run = 0;
	int rdy_mode_age = 0;

	min_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_MSG_LINES) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		err_count++;
	endtask

	// Work out the result of one request and advance the shadow queue.
	function automatic rsp_t next_queue_result(input req_t item);
		rsp_t r;
		int best;
		r = '0;
		if (item.operation == OP_INSERT) begin
			if (shadow_count < CAPACITY) begin
				shadow_vals[shadow_count] = item.value;
				shadow_count++;
				r.status = ST_INSERTED;
			end else begin
				r.status = ST_FULL;
			end
		end else if (shadow_count == 0) begin
			r.removed_value = VALUE_NONE;
			r.status = ST_EMPTY;
		end else begin
			// earliest of the smallest wins; close the gap behind it
			best = 0;
			for (int i = 1; i < shadow_count; i++) begin
				if (shadow_vals[i] < shadow_vals[best]) best = i;
			end
			r.removed_value = shadow_vals[best];
			for (int i = best; i < shadow_count - 1; i++) begin
				shadow_vals[i] = shadow_vals[i + 1];
			end
			shadow_count--;
			r.status = ST_REMOVED;
		end
		r.queue_count = QCOUNT_W'(shadow_count);
		return r;
	endfunction

	function automatic void add_row(input op_t op, input logic signed [VAL_W-1:0] val,
			input bit typed, input logic signed [VAL_W-1:0] want_val,
			input status_t want_st, input int want_cnt);
		dir_row_t row;
		row.item.operation = op;
		row.item.value = val;
		row.typed = typed;
		row.want.removed_value = want_val;
		row.want.status = want_st;
		row.want.queue_count = QCOUNT_W'(want_cnt);
		dir_rows.push_back(row);
	endfunction

	function automatic req_t random_item(input int insert_pct);
		req_t item;
		item.operation = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
		case ($urandom_range(0, 9))
			0: item.value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1, 2, 3: item.value = int'($urandom_range(0, 8)) - 4;
			4: item.value = $urandom_range(0, 1) ? 32'sh7fffffff - int'($urandom_range(0, 3))
				: 32'sh80000000 + int'($urandom_range(0, 3));
			default: item.value = $urandom;
		endcase
		return item;
	endfunction

	// Offer one request and hold it until the transfer; end bursts with a gap.
	task automatic send_item(input req_t item, input bit typed, input rsp_t want);
		int gap;
		req <= item;
		req_valid <= 1'b1;
		tag_typed <= typed;
		tag_want <= want;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	// Stall the receiver on its own pattern, switching style now and then.
	always @(posedge clk) begin
		rdy_mode_age++;
		if (rdy_mode_age >= 150) begin
			rdy_mode_age = 0;
			rdy_mode = $urandom_range(READY_FREE, READY_BURSTY);
		end
		if (rdy_run > 0) begin
			rdy_run--;
		end else begin
			case (rdy_mode)
				READY_FREE: begin
					rsp_ready <= 1'b1;
					rdy_run = $urandom_range(0, 40);
				end
				READY_CHOPPY: begin
					rsp_ready <= 1'($urandom_range(0, 1));
					rdy_run = $urandom_range(0, 2);
				end
				default: begin
					rsp_ready <= !rsp_ready;
					rdy_run = rsp_ready ? $urandom_range(0, 30) : $urandom_range(0, 8);
				end
			endcase
		end
	end

	// Record each request transfer and check each result transfer.
	always @(posedge clk) begin
		rsp_t pred;
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result value=%0d status=%s count=%0d",
						rsp.removed_value, rsp.status.name(), rsp.queue_count));
				end else begin
					want = pending_results.pop_front();
					if (rsp.removed_value !== want.removed_value)
						report_mismatch($sformatf("removed_value got %0d want %0d",
							rsp.removed_value, want.removed_value));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							rsp.status, want.status));
					if (rsp.queue_count !== want.queue_count)
						report_mismatch($sformatf("queue_count got %0d want %0d",
							rsp.queue_count, want.queue_count));
				end
			end
			if (req_valid && req_ready) begin
				pred = next_queue_result(req);
				pending_results.push_back(tag_typed ? tag_want : pred);
			end
		end
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int phase_len;
		int insert_pct;
		rsp_t no_want;
		no_want = '0;

		// extremes, empty remove, ties, fill up to a refused insert, then drain two and insert
		add_row(OP_REMOVE, 32'sh7fffffff, 1, VALUE_NONE, ST_EMPTY, 0);
		add_row(OP_INSERT, 32'sh7fffffff, 1, 0, ST_INSERTED, 1);
		add_row(OP_INSERT, 32'sh80000000, 1, 0, ST_INSERTED, 2);
		add_row(OP_INSERT, -32'sd1, 1, 0, ST_INSERTED, 3);
		add_row(OP_INSERT, 32'sd0, 1, 0, ST_INSERTED, 4);
		add_row(OP_REMOVE, 32'sd0, 1, 32'sh80000000, ST_REMOVED, 3);
		add_row(OP_REMOVE, 32'sh55555555, 1, -32'sd1, ST_REMOVED, 2);
		add_row(OP_INSERT, 32'sd5, 0, 0, ST_INSERTED, 0);
		add_row(OP_INSERT, 32'sd5, 0, 0, ST_INSERTED, 0);
		add_row(OP_INSERT, 32'shaaaaaaaa, 0, 0, ST_INSERTED, 0);
		add_row(OP_INSERT, 32'sd5, 0, 0, ST_INSERTED, 0);
		for (int i = 0; i < 10; i++) begin
			add_row(OP_INSERT, (i % 2) ? 32'sh55555555 : -32'sd7 + i, 0, 0, ST_INSERTED, 0);
		end
		add_row(OP_INSERT, 32'sh12345678, 1, 0, ST_FULL, CAPACITY);
		add_row(OP_REMOVE, 32'sd0, 0, 0, ST_REMOVED, 0);
		add_row(OP_REMOVE, 32'sd0, 0, 0, ST_REMOVED, 0);
		add_row(OP_INSERT, 32'sh55555555, 0, 0, ST_INSERTED, 0);

		// hold reset, then release on an edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 16);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		end

		// random phases that lean toward filling, draining or neither
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 3))
				0: insert_pct = 85;
				1: insert_pct = 15;
				2: insert_pct = 50;
				default: insert_pct = 60;
			endcase
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				send_item(random_item(insert_pct), 1'b0, no_want);
				sent++;
			end
		end
		req_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
